// ----- sv/swcm_pkg.sv -----
// Shared types and constants for the shallow-water Courant maximum core.
`timescale 1ns / 1ps
package swcm_pkg;

   localparam int DEF_FRAC_BITS = 16;
   localparam int WORD_W        = 32;
   localparam int CSR_INDEX_W   = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_DT_OVER_DX = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DT_OVER_DY = 2'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL_G,
      ST_SQRT,
      ST_ADD,
      ST_MUL_X,
      ST_MUL_Y,
      ST_SUM,
      ST_UPDATE
   } state_type;

endpackage

// ----- sv/shallow_water_courant_max_core.sv -----
// Top level: per-cell Courant number and running maximum over a sweep.
// A new cell is taken only in the idle state, once the previous cell has left its
// update step; the cell rate is set by the bit-serial square root, one root bit a
// cycle, and the single shared 32x32 multiplier; a last cell holds in its update
// step while the previous result beat is not taken.
// Reset clears the sequencer, the running maximum and the output valid and
// loads both timestep ratios with 1.0.
`timescale 1ns / 1ps
module shallow_water_courant_max_core #(
   parameter int FRAC_BITS = swcm_pkg::DEF_FRAC_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [3*swcm_pkg::WORD_W-1:0]       req_tdata,   // depth, vel_x, vel_y
   input  logic                                req_tlast,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [swcm_pkg::WORD_W-1:0]         rsp_tdata,   // max_courant
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [swcm_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [swcm_pkg::WORD_W-1:0]         csr_data
);
   import swcm_pkg::*;

   localparam longint unsigned G_RAW_L = ((64'd981 << FRAC_BITS) + 64'd50) / 64'd100;
   localparam int G_W        = FRAC_BITS + 4;
   localparam int PROD_W     = (WORD_W - 1) + G_W;
   localparam int SQRT_STEPS = (PROD_W + 1) / 2;
   localparam int REM_W      = SQRT_STEPS + 2;
   localparam int CNT_W      = $clog2(SQRT_STEPS);
   localparam int SUM_W      = 2 * WORD_W + 1 - FRAC_BITS;
   localparam logic [WORD_W-1:0] G_RAW  = G_RAW_L[WORD_W-1:0];
   localparam logic [CNT_W-1:0]  CNT_LAST = CNT_W'(SQRT_STEPS - 1);

   state_type state_ff, state_in;

   logic [WORD_W-1:0]     dtx_ff, dtx_in, dty_ff, dty_in;
   logic [WORD_W-1:0]     depth_ff, depth_in;
   logic [WORD_W-1:0]     spd_x_ff, spd_x_in, spd_y_ff, spd_y_in;
   logic                  last_ff, last_in;
   logic [2*WORD_W-1:0]   prod_ff, prod_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [SQRT_STEPS-1:0] root_ff, root_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [SUM_W-1:0]      acc_ff, acc_in;
   logic [WORD_W-1:0]     cn_ff, cn_in;
   logic [WORD_W-1:0]     max_ff, max_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [WORD_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [WORD_W-1:0]     mul_a, mul_b;
   logic [REM_W-1:0]      rem_shift, trial;
   logic [SUM_W-1:0]      sum;
   logic [WORD_W-1:0]     new_max;
   logic [WORD_W-1:0]     vx_raw, vy_raw;
   logic                  emit_blocked;

   assign vx_raw       = req_tdata[2*WORD_W-1:WORD_W];
   assign vy_raw       = req_tdata[3*WORD_W-1:2*WORD_W];
   assign rem_shift    = {rem_ff[REM_W-3:0], prod_ff[2*SQRT_STEPS-1 -: 2]};
   assign trial        = {root_ff, 2'b01};
   assign sum          = acc_ff + SUM_W'(prod_ff >> FRAC_BITS);
   assign new_max      = (cn_ff > max_ff) ? cn_ff : max_ff;
   assign emit_blocked = rsp_valid_ff && !rsp_tready;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign csr_ready  = 1'b1;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_MUL_G;
         ST_MUL_G:  state_in = ST_SQRT;
         ST_SQRT:   if (cnt_ff == CNT_LAST) state_in = ST_ADD;
         ST_ADD:    state_in = ST_MUL_X;
         ST_MUL_X:  state_in = ST_MUL_Y;
         ST_MUL_Y:  state_in = ST_SUM;
         ST_SUM:    state_in = ST_UPDATE;
         ST_UPDATE: if (!(last_ff && emit_blocked)) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      mul_a = depth_ff;
      mul_b = G_RAW;
      case (state_ff)
         ST_MUL_X: begin
            mul_a = spd_x_ff;
            mul_b = dtx_ff;
         end
         ST_MUL_Y: begin
            mul_a = spd_y_ff;
            mul_b = dty_ff;
         end
         default: begin
            mul_a = depth_ff;
            mul_b = G_RAW;
         end
      endcase
   end

   always_comb begin
      dtx_in       = dtx_ff;
      dty_in       = dty_ff;
      depth_in     = depth_ff;
      spd_x_in     = spd_x_ff;
      spd_y_in     = spd_y_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      cn_in        = cn_ff;
      max_in       = max_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      if (csr_valid) begin
         if (csr_index == CSR_DT_OVER_DX) dtx_in = csr_data;
         if (csr_index == CSR_DT_OVER_DY) dty_in = csr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               depth_in = req_tdata[WORD_W-1] ? '0 : req_tdata[WORD_W-1:0];
               spd_x_in = vx_raw[WORD_W-1] ? (~vx_raw + 1'b1) : vx_raw;
               spd_y_in = vy_raw[WORD_W-1] ? (~vy_raw + 1'b1) : vy_raw;
               last_in  = req_tlast;
            end
         end
         ST_MUL_G: begin
            prod_in = mul_a * mul_b;
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
         end
         ST_SQRT: begin
            prod_in = prod_ff << 2;
            cnt_in  = cnt_ff + 1'b1;
            if (rem_shift >= trial) begin
               rem_in  = rem_shift - trial;
               root_in = {root_ff[SQRT_STEPS-2:0], 1'b1};
            end else begin
               rem_in  = rem_shift;
               root_in = {root_ff[SQRT_STEPS-2:0], 1'b0};
            end
         end
         ST_ADD: begin
            spd_x_in = spd_x_ff + WORD_W'(root_ff);
            spd_y_in = spd_y_ff + WORD_W'(root_ff);
         end
         ST_MUL_X: begin
            prod_in = mul_a * mul_b;
            acc_in  = '0;
         end
         ST_MUL_Y: begin
            acc_in  = SUM_W'(prod_ff >> FRAC_BITS);
            prod_in = mul_a * mul_b;
         end
         ST_SUM: begin
            cn_in = (sum[SUM_W-1:WORD_W] != '0) ? '1 : sum[WORD_W-1:0];
         end
         ST_UPDATE: begin
            if (!last_ff) begin
               max_in = new_max;
            end else if (!emit_blocked) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = new_max;
               max_in       = '0;
            end
         end
         default: begin
            cnt_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dtx_ff       <= WORD_W'(64'd1 << FRAC_BITS);
         dty_ff       <= WORD_W'(64'd1 << FRAC_BITS);
         max_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         dtx_ff       <= dtx_in;
         dty_ff       <= dty_in;
         max_ff       <= max_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      depth_ff    <= depth_in;
      spd_x_ff    <= spd_x_in;
      spd_y_ff    <= spd_y_in;
      last_ff     <= last_in;
      prod_ff     <= prod_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      acc_ff      <= acc_in;
      cn_ff       <= cn_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTHESIS
   a_sqrt_exit: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SQRT && cnt_ff == CNT_LAST) |=> (state_ff == ST_ADD))
      else $error("square root did not finish after its last step");

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_UPDATE && $past(last_ff)))
      else $error("result beat raised outside a last-cell update");

   a_max_cleared: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && last_ff && !emit_blocked) |=> (max_ff == '0))
      else $error("running maximum not cleared after sweep end");

   a_max_monotone: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UPDATE && !last_ff) |=> (max_ff >= $past(max_ff)))
      else $error("running maximum decreased within a sweep");
`endif

endmodule
